@@ sv/rcfp_pkg.sv @@
// Shared types and constants for the RGB command frame parser.
// Depends on nothing; imported by rcfp_frame_accum and the top level.
`default_nettype none
package rcfp_pkg;

	localparam int unsigned FRAME_LENGTH = 18;
	localparam int unsigned BUF_SLOTS    = 20;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned VAL_W        = 16;
	localparam int unsigned SUM_W        = VAL_W + 2;

	localparam logic [POS_W-1:0] POS_MAX     = 5'd31;
	localparam logic [POS_W-1:0] FIELD_FIRST = 5'd2;
	localparam logic [POS_W-1:0] FIELD_LAST  = 5'd16;

	localparam logic [POS_W-1:0] POS_H = 5'd0;
	localparam logic [POS_W-1:0] POS_R = 5'd1;
	localparam logic [POS_W-1:0] POS_G = 5'd5;
	localparam logic [POS_W-1:0] POS_B = 5'd9;
	localparam logic [POS_W-1:0] POS_S = 5'd13;

	localparam logic [7:0] CHAR_H = 8'h48;
	localparam logic [7:0] CHAR_R = 8'h52;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_B = 8'h42;
	localparam logic [7:0] CHAR_S = 8'h53;

	localparam logic [9:0] DIGIT_BIAS = 10'd48;

	// digit place within a field
	localparam logic [1:0] PLACE_HUND = 2'd0;
	localparam logic [1:0] PLACE_TENS = 2'd1;
	localparam logic [1:0] PLACE_ONES = 2'd2;
	localparam logic [1:0] PLACE_GAP  = 2'd3;

	// field index
	localparam logic [1:0] FLD_RED   = 2'd0;
	localparam logic [1:0] FLD_GREEN = 2'd1;
	localparam logic [1:0] FLD_BLUE  = 2'd2;
	localparam logic [1:0] FLD_SUM   = 2'd3;

	typedef struct packed {
		logic                    status;
		logic signed [VAL_W-1:0] red;
		logic signed [VAL_W-1:0] green;
		logic signed [VAL_W-1:0] blue;
	} rcfp_result_t;

	typedef struct packed {
		logic       is_marker;
		logic [7:0] expected;
	} rcfp_marker_t;

	function automatic rcfp_marker_t marker_at(input logic [POS_W-1:0] pos);
		rcfp_marker_t m;
		m.is_marker = 1'b1;
		unique case (pos)
			POS_H: m.expected = CHAR_H;
			POS_R: m.expected = CHAR_R;
			POS_G: m.expected = CHAR_G;
			POS_B: m.expected = CHAR_B;
			POS_S: m.expected = CHAR_S;
			default: begin
				m.is_marker = 1'b0;
				m.expected  = 8'h00;
			end
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

@@ sv/rcfp_frame_accum.sv @@
// Per-burst state of the frame parser: position, length, marker check and digit sums.
// Produces the frame verdict for the byte being taken. Depends on rcfp_pkg.
`default_nettype none
module rcfp_frame_accum (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 burst_end,
	output rcfp_pkg::rcfp_result_t    result
);
	import rcfp_pkg::*;

	logic [POS_W-1:0]        pos_q;
	logic                    zero_seen_q;
	logic [POS_W-1:0]        len_q;
	logic                    markers_ok_q;
	logic signed [VAL_W-1:0] red_q, green_q, blue_q, sum_q;

	logic [POS_W-1:0]        pos_n, len_n, rel;
	logic                    zero_seen_n, markers_ok_n, in_buf, in_field;
	logic signed [VAL_W-1:0] red_n, green_n, blue_n, sum_n;
	logic signed [9:0]       digit;
	logic signed [VAL_W-1:0] digit_x, term;
	logic signed [SUM_W-1:0] rgb_total;
	rcfp_marker_t            mk;
	logic                    ok;

	always_comb begin
		in_buf   = pos_q < POS_W'(BUF_SLOTS);
		digit    = $signed({2'b00, rx_byte} - DIGIT_BIAS);
		digit_x  = VAL_W'(digit);
		rel      = pos_q - FIELD_FIRST;
		in_field = in_buf && (pos_q >= FIELD_FIRST) && (pos_q <= FIELD_LAST)
			&& (rel[1:0] != PLACE_GAP);
		mk       = marker_at(pos_q);

		case (rel[1:0])
			PLACE_HUND: term = (digit_x <<< 6) + (digit_x <<< 5) + (digit_x <<< 2);
			PLACE_TENS: term = (digit_x <<< 3) + (digit_x <<< 1);
			default:    term = digit_x;
		endcase

		pos_n        = (pos_q == POS_MAX) ? pos_q : pos_q + 5'd1;
		zero_seen_n  = zero_seen_q;
		len_n        = len_q;
		markers_ok_n = markers_ok_q;
		red_n        = red_q;
		green_n      = green_q;
		blue_n       = blue_q;
		sum_n        = sum_q;

		if (in_buf) begin
			if (!zero_seen_q) begin
				if (rx_byte == 8'h00) zero_seen_n = 1'b1;
				else len_n = len_q + 5'd1;
			end
			if (mk.is_marker && rx_byte != mk.expected) markers_ok_n = 1'b0;
		end
		if (in_field) begin
			case (rel[3:2])
				FLD_RED:   red_n   = red_q + term;
				FLD_GREEN: green_n = green_q + term;
				FLD_BLUE:  blue_n  = blue_q + term;
				default:   sum_n   = sum_q + term;
			endcase
		end

		// compare at full width so a wrapped total cannot match
		rgb_total = SUM_W'(red_n) + SUM_W'(green_n) + SUM_W'(blue_n);
		ok = (len_n == POS_W'(FRAME_LENGTH)) && markers_ok_n
			&& (rgb_total == SUM_W'(sum_n));

		result.status = !ok;
		result.red    = ok ? red_n   : '0;
		result.green  = ok ? green_n : '0;
		result.blue   = ok ? blue_n  : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			zero_seen_q  <= 1'b0;
			len_q        <= '0;
			markers_ok_q <= 1'b1;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
			sum_q        <= '0;
		end else if (take) begin
			if (burst_end) begin
				// clear for the next burst
				pos_q        <= '0;
				zero_seen_q  <= 1'b0;
				len_q        <= '0;
				markers_ok_q <= 1'b1;
				red_q        <= '0;
				green_q      <= '0;
				blue_q       <= '0;
				sum_q        <= '0;
			end else begin
				pos_q        <= pos_n;
				zero_seen_q  <= zero_seen_n;
				len_q        <= len_n;
				markers_ok_q <= markers_ok_n;
				red_q        <= red_n;
				green_q      <= green_n;
				blue_q       <= blue_n;
				sum_q        <= sum_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/rgb_command_frame_parser_top.sv @@
// RGB command frame parser, top level: input register, frame accumulator, result register.
// Depends on rcfp_pkg and rcfp_frame_accum.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one received byte per request, with
//   burst_end marking the last byte of a burst. Output channel (out_valid/out_ready)
//   moves one result per burst: status 0 with red, green and blue decoded, or
//   status 1 (negative acknowledge) with the colour fields zero.
//   A taken byte goes into the input register; if it ends a burst, the frame
//   accumulator's verdict for it is loaded into the result register, from
//   which the receiver takes it.
//   Throughput: one byte per cycle. Bytes that do not end a burst never wait on
//   the output side; a burst-ending byte waits in the input register only while
//   the result register still holds an untaken result.
//   Reset clears the burst state and the valid flags of the input register and
//   the result register; no request is pending afterwards.
//   When the receiver stalls, the result register holds its value and the input
//   register keeps taking bytes until a second burst end reaches it.
`default_nettype none
module rgb_command_frame_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        burst_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic signed [15:0] red,
	output logic signed [15:0] green,
	output logic signed [15:0] blue
);
	import rcfp_pkg::*;

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         burst_end_s1;
	logic         adv_s1;
	logic         out_valid_q;
	rcfp_result_t res_q;
	rcfp_result_t res_c;

	// a burst end needs a result register that is empty or being taken, other bytes always move on
	assign adv_s1   = valid_s1 && (!burst_end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1   <= rx_byte;
			burst_end_s1 <= burst_end;
		end
	end

	rcfp_frame_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv_s1),
		.rx_byte   (rx_byte_s1),
		.burst_end (burst_end_s1),
		.result    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && burst_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && burst_end_s1) begin
			res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign red       = res_q.red;
	assign green     = res_q.green;
	assign blue      = res_q.blue;

	a_nack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status |-> res_q.red == '0 && res_q.green == '0
			&& res_q.blue == '0)
		else $error("negative acknowledge carries nonzero colour");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && burst_end_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked burst end");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && burst_end_s1 && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("burst end did not reach the result register");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("pending result dropped or changed");

endmodule
`default_nettype wire
